// File: rtl/core/fbl_pkg.sv
// Shared types and constants for the face box landmark check block.
`default_nettype none

package fbl_pkg;

    localparam int COORD_W    = 16;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 8;
    localparam int BOX_W      = 13;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_TEST  = 2'd2,
        OP_END   = 2'd3
    } t_op;

    typedef struct packed {
        logic signed [SUM_W-1:0]   sum;
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
    } t_axis_stats;

endpackage

`default_nettype wire

// File: rtl/core/fbl_axis_fit.sv
// One-axis fit test: landmark span against 1.5x size, mean against the rectangle centre.
`default_nettype none

module fbl_axis_fit
    import fbl_pkg::*;
#(
    parameter int PIXEL_BITS = 12
) (
    input  wire t_axis_stats           i_stats,
    input  wire logic [CNT_W-1:0]      i_count,
    input  wire logic [PIXEL_BITS-1:0] i_edge,
    input  wire logic [PIXEL_BITS-1:0] i_size,
    output logic                       o_fit
);

    localparam int CW  = PIXEL_BITS + 5;
    localparam int HW  = PIXEL_BITS + 3;
    localparam int PCW = CNT_W + CW;
    localparam int PHW = CNT_W + HW;
    localparam int DW  = ((PCW > SUM_W) ? PCW : SUM_W) + 2;
    localparam int SPW = ((PIXEL_BITS + 6) > (COORD_W + 2)) ? (PIXEL_BITS + 6) : (COORD_W + 2);

    logic [PIXEL_BITS-2:0] half;
    logic [PIXEL_BITS:0]   centre;
    logic [CW-1:0]         centre16;
    logic [HW-1:0]         half16;
    logic [PCW-1:0]        prod_c;
    logic [PHW-1:0]        prod_h;
    logic signed [DW-1:0]  dev;
    logic [DW-1:0]         mag;
    logic signed [SPW-1:0] span;
    logic signed [SPW-1:0] limit;
    logic                  span_ok;
    logic                  mean_ok;

    always_comb begin
        half     = i_size[PIXEL_BITS-1:1];
        centre   = (PIXEL_BITS+1)'(i_edge) + (PIXEL_BITS+1)'(half);
        centre16 = {centre, 4'b0000};
        half16   = {half, 4'b0000};
        prod_c   = PCW'(i_count) * PCW'(centre16);
        prod_h   = PHW'(i_count) * PHW'(half16);
        dev      = DW'($signed(i_stats.sum)) - $signed(DW'(prod_c));
        mag      = dev[DW-1] ? DW'(-dev) : DW'(dev);
        mean_ok  = mag <= DW'(prod_h);
        span     = SPW'($signed(i_stats.hi)) - SPW'($signed(i_stats.lo));
        limit    = $signed(SPW'({i_size, 4'b0000}) + SPW'({i_size, 3'b000}));
        span_ok  = !(span > limit);
        o_fit    = span_ok && mean_ok;
    end

endmodule

`default_nettype wire

// File: rtl/core/face_box_landmark_check_core.sv
// Top level of the face box landmark check block: landmark statistics and rectangle test.
//
//  channel  dir  tdata (low bit up)                         tuser
//  s_axis   in   point_x, point_y, rect_left, rect_top,     operation
//                rect_width, rect_height, zero pad
//  m_axis   out  box_left, box_top, box_width, box_height,  found
//                zero pad
//
//  An input transfer lands in the input register; from there it is applied to the
//  landmark state and any result is written to the output register.
//  One item per cycle is sustained while no output result is held; the fit test is one
//  pass of an 8 by (PIXEL_BITS+5)-bit and an 8 by (PIXEL_BITS+3)-bit multiplier per axis.
//  Reset clears the state, the match flag and both valid flags.
//  A held output result stalls the input register, and s_axis_tready follows it.
`default_nettype none

module face_box_landmark_check_core
    import fbl_pkg::*;
#(
    parameter int MAX_POINTS = 128,
    parameter int PIXEL_BITS = 12
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // point_x, point_y, rect_left, rect_top, rect_width, rect_height, zero pad
    input  wire logic [((32 + 4*PIXEL_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // operation
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // box_left, box_top, box_width, box_height, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // found
    output logic [0:0]                 m_axis_tuser
);

    localparam int IN_DATA_W = ((32 + 4*PIXEL_BITS + 7) / 8) * 8;
    localparam int RL_LO = 32;
    localparam int RT_LO = RL_LO + PIXEL_BITS;
    localparam int RW_LO = RT_LO + PIXEL_BITS;
    localparam int RH_LO = RW_LO + PIXEL_BITS;

    logic                  r_in_valid;
    logic [1:0]            r_in_user;
    logic [IN_DATA_W-1:0]  r_in_data;

    logic [CNT_W-1:0]          r_count,  n_count;
    logic signed [SUM_W-1:0]   r_sum_x,  n_sum_x;
    logic signed [SUM_W-1:0]   r_sum_y,  n_sum_y;
    logic signed [COORD_W-1:0] r_lo_x,   n_lo_x;
    logic signed [COORD_W-1:0] r_hi_x,   n_hi_x;
    logic signed [COORD_W-1:0] r_lo_y,   n_lo_y;
    logic signed [COORD_W-1:0] r_hi_y,   n_hi_y;
    logic                      r_match,  n_match;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_found;

    logic                      proc;
    logic                      emit;
    logic                      emit_found;
    t_op                       op;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic [PIXEL_BITS-1:0]     rl, rt, rw, rh;
    t_axis_stats               stats_x;
    t_axis_stats               stats_y;
    logic                      fit_x;
    logic                      fit_y;

    assign proc          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_found;

    assign op = t_op'(r_in_user);
    assign px = $signed(r_in_data[15:0]);
    assign py = $signed(r_in_data[31:16]);
    assign rl = r_in_data[RL_LO +: PIXEL_BITS];
    assign rt = r_in_data[RT_LO +: PIXEL_BITS];
    assign rw = r_in_data[RW_LO +: PIXEL_BITS];
    assign rh = r_in_data[RH_LO +: PIXEL_BITS];

    assign stats_x = '{sum: r_sum_x, lo: r_lo_x, hi: r_hi_x};
    assign stats_y = '{sum: r_sum_y, lo: r_lo_y, hi: r_hi_y};

    fbl_axis_fit #(.PIXEL_BITS(PIXEL_BITS)) u_fit_x (
        .i_stats (stats_x),
        .i_count (r_count),
        .i_edge  (rl),
        .i_size  (rw),
        .o_fit   (fit_x)
    );

    fbl_axis_fit #(.PIXEL_BITS(PIXEL_BITS)) u_fit_y (
        .i_stats (stats_y),
        .i_count (r_count),
        .i_edge  (rt),
        .i_size  (rh),
        .o_fit   (fit_y)
    );

    always_comb begin
        n_count    = r_count;
        n_sum_x    = r_sum_x;
        n_sum_y    = r_sum_y;
        n_lo_x     = r_lo_x;
        n_hi_x     = r_hi_x;
        n_lo_y     = r_lo_y;
        n_hi_y     = r_hi_y;
        n_match    = r_match;
        emit       = 1'b0;
        emit_found = 1'b0;
        case (op)
            OP_CLEAR: begin
                n_count = '0;
                n_sum_x = '0;
                n_sum_y = '0;
                n_lo_x  = '0;
                n_hi_x  = '0;
                n_lo_y  = '0;
                n_hi_y  = '0;
                n_match = 1'b0;
            end
            OP_ADD: begin
                if (r_count < CNT_W'(MAX_POINTS)) begin
                    if (r_count == '0) begin
                        n_lo_x = px;
                        n_hi_x = px;
                        n_lo_y = py;
                        n_hi_y = py;
                    end else begin
                        if (px < r_lo_x) n_lo_x = px;
                        if (px > r_hi_x) n_hi_x = px;
                        if (py < r_lo_y) n_lo_y = py;
                        if (py > r_hi_y) n_hi_y = py;
                    end
                    n_sum_x = r_sum_x + SUM_W'(px);
                    n_sum_y = r_sum_y + SUM_W'(py);
                    n_count = r_count + 1'b1;
                end
            end
            OP_TEST: begin
                if (!r_match && r_count != '0 && fit_x && fit_y) begin
                    n_match    = 1'b1;
                    emit       = 1'b1;
                    emit_found = 1'b1;
                end
            end
            OP_END: begin
                emit    = !r_match;
                n_match = 1'b0;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_user <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_lo_x  <= '0;
            r_hi_x  <= '0;
            r_lo_y  <= '0;
            r_hi_y  <= '0;
            r_match <= 1'b0;
        end else if (proc) begin
            r_count <= n_count;
            r_sum_x <= n_sum_x;
            r_sum_y <= n_sum_y;
            r_lo_x  <= n_lo_x;
            r_hi_x  <= n_hi_x;
            r_lo_y  <= n_lo_y;
            r_hi_y  <= n_hi_y;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && emit) begin
            r_out_found <= emit_found;
            if (emit_found) begin
                r_out_data <= {(OUT_DATA_W - 4*BOX_W)'(0), BOX_W'(rh), BOX_W'(rw),
                               BOX_W'(rt), BOX_W'(rl)};
            end else begin
                r_out_data <= {(OUT_DATA_W - 4*BOX_W)'(0), {(4*BOX_W){1'b1}}};
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fbl_check.sv
// Port-level checker for the face box landmark check block, bound to the top level.
`default_nettype none

module fbl_check
    import fbl_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]            m_axis_tuser
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_none_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata[4*BOX_W-1:0] == {(4*BOX_W){1'b1}})
        else $error("no-match result not all ones");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:4*BOX_W] == '0)
        else $error("output pad bits set");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind face_box_landmark_check_core fbl_check u_fbl_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/tb_face_box_landmark_check_core.sv
// Self-checking testbench for the face box landmark check core.
`timescale 1ns / 100ps

module tb_face_box_landmark_check_core;
    import fbl_pkg::*;

    localparam int PIXEL_BITS  = 12;
    localparam int IN_DATA_W   = ((32 + 4*PIXEL_BITS + 7) / 8) * 8;
    localparam int LIST_POINTS = 128;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 12;

    typedef struct {
        logic              found;
        logic signed [12:0] left;
        logic signed [12:0] top;
        logic signed [12:0] width;
        logic signed [12:0] height;
    } t_box_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = OP_CLEAR;
    logic                 m_ready = 1'b0;
    wire                  s_axis_tready;
    wire                  m_axis_tvalid;
    wire [OUT_DATA_W-1:0] m_axis_tdata;
    wire [0:0]            m_axis_tuser;

    face_box_landmark_check_core #(
        .MAX_POINTS(LIST_POINTS),
        .PIXEL_BITS(PIXEL_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tuser (s_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // landmark statistics as the block should hold them
    int lm_count;
    int lm_sum_x;
    int lm_sum_y;
    int lm_least_x;
    int lm_greatest_x;
    int lm_least_y;
    int lm_greatest_y;
    bit list_matched;

    t_box_result expected_boxes[$];
    int  mismatch_count = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  tx_steady = 1'b0;
    bit  rx_steady = 1'b0;
    int  hold_length = 0;
    int  hold_serial = 0;
    int  hold_taken = 0;
    int  hold_left = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls or steady ready, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_serial != hold_taken) begin
            hold_taken = hold_serial;
            hold_left = hold_length;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge i_clk) begin
        t_box_result exp_box;
        if (i_rst_n && m_axis_tvalid && m_ready) begin
            if (expected_boxes.size() == 0) begin
                $error("unexpected result transfer: tdata %h found %b",
                       m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                exp_box = expected_boxes.pop_front();
                if (m_axis_tuser[0] !== exp_box.found) begin
                    $error("found: expected %0d, got %0d", exp_box.found, m_axis_tuser[0]);
                    mismatch_count++;
                end
                if ($signed(m_axis_tdata[12:0]) !== exp_box.left) begin
                    $error("box_left: expected %0d, got %0d", exp_box.left,
                           $signed(m_axis_tdata[12:0]));
                    mismatch_count++;
                end
                if ($signed(m_axis_tdata[25:13]) !== exp_box.top) begin
                    $error("box_top: expected %0d, got %0d", exp_box.top,
                           $signed(m_axis_tdata[25:13]));
                    mismatch_count++;
                end
                if ($signed(m_axis_tdata[38:26]) !== exp_box.width) begin
                    $error("box_width: expected %0d, got %0d", exp_box.width,
                           $signed(m_axis_tdata[38:26]));
                    mismatch_count++;
                end
                if ($signed(m_axis_tdata[51:39]) !== exp_box.height) begin
                    $error("box_height: expected %0d, got %0d", exp_box.height,
                           $signed(m_axis_tdata[51:39]));
                    mismatch_count++;
                end
            end
        end
    end

    function automatic bit axis_fits(int sum, int lo, int hi, int pos, int size);
        longint centre16;
        longint half16;
        longint dev;
        centre16 = (longint'(pos) + size / 2) * 16;
        half16 = longint'(size / 2) * 16;
        if (longint'(hi) - lo > longint'(size) * 24) return 1'b0;
        dev = longint'(sum) - longint'(lm_count) * centre16;
        if (dev < 0) dev = -dev;
        return dev <= longint'(lm_count) * half16;
    endfunction

    function automatic void reset_landmarks();
        lm_count = 0;
        lm_sum_x = 0;
        lm_sum_y = 0;
        lm_least_x = 0;
        lm_greatest_x = 0;
        lm_least_y = 0;
        lm_greatest_y = 0;
    endfunction

    function automatic void apply_landmark_item(t_op op, logic signed [15:0] px,
                                                logic signed [15:0] py, logic [11:0] rl,
                                                logic [11:0] rt, logic [11:0] rw,
                                                logic [11:0] rh);
        t_box_result box;
        case (op)
            OP_CLEAR: begin
                reset_landmarks();
                list_matched = 1'b0;
            end
            OP_ADD: begin
                if (lm_count < LIST_POINTS) begin
                    if (lm_count == 0) begin
                        lm_least_x = int'(px);
                        lm_greatest_x = int'(px);
                        lm_least_y = int'(py);
                        lm_greatest_y = int'(py);
                    end else begin
                        if (px < lm_least_x) lm_least_x = int'(px);
                        if (px > lm_greatest_x) lm_greatest_x = int'(px);
                        if (py < lm_least_y) lm_least_y = int'(py);
                        if (py > lm_greatest_y) lm_greatest_y = int'(py);
                    end
                    lm_sum_x += int'(px);
                    lm_sum_y += int'(py);
                    lm_count++;
                end
            end
            OP_TEST: begin
                if (!list_matched && lm_count != 0
                        && axis_fits(lm_sum_x, lm_least_x, lm_greatest_x,
                                     int'(rl), int'(rw))
                        && axis_fits(lm_sum_y, lm_least_y, lm_greatest_y,
                                     int'(rt), int'(rh))) begin
                    list_matched = 1'b1;
                    box.found = 1'b1;
                    box.left = {1'b0, rl};
                    box.top = {1'b0, rt};
                    box.width = {1'b0, rw};
                    box.height = {1'b0, rh};
                    expected_boxes = {expected_boxes, box};
                end
            end
            default: begin
                if (list_matched) begin
                    list_matched = 1'b0;
                end else begin
                    box.found = 1'b0;
                    box.left = -13'sd1;
                    box.top = -13'sd1;
                    box.width = -13'sd1;
                    box.height = -13'sd1;
                    expected_boxes = {expected_boxes, box};
                end
            end
        endcase
    endfunction

    task automatic send_item(t_op op, logic signed [15:0] px, logic signed [15:0] py,
                             logic [11:0] rl, logic [11:0] rt, logic [11:0] rw,
                             logic [11:0] rh);
        if (!tx_steady) begin
            while ($urandom_range(0, 99) < 37) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_valid <= 1'b1;
        s_tdata <= {rh, rw, rt, rl, py, px};
        s_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_landmark_item(op, px, py, rl, rt, rw, rh);
        items_sent++;
    endtask

    task automatic send_point(int px, int py);
        send_item(OP_ADD, px[15:0], py[15:0], '0, '0, '0, '0);
    endtask

    task automatic send_rect(int rl, int rt, int rw, int rh);
        send_item(OP_TEST, '0, '0, rl[11:0], rt[11:0], rw[11:0], rh[11:0]);
    endtask

    task automatic send_op(t_op op);
        send_item(op, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic send_noise();
        send_item(t_op'($urandom_range(0, 3)), 16'($urandom()), 16'($urandom()),
                  12'($urandom()), 12'($urandom()), 12'($urandom()), 12'($urandom()));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (expected_boxes.size() != 0) @(posedge i_clk);
    endtask

    // rectangle on one axis aimed at the current landmark mean
    function automatic void pick_fit(int sum, int lo, int hi, bit tight,
                                     output logic [11:0] pos, output logic [11:0] size);
        int s;
        int m;
        int p;
        if (lm_count == 0) begin
            pos = 12'($urandom());
            size = 12'($urandom());
            return;
        end
        s = (hi - lo + 23) / 24 + (tight ? 0 : $urandom_range(0, 80));
        if (s > 4095) s = 4095;
        m = sum / (16 * lm_count);
        p = m - s / 2 + (tight ? 0 : int'($urandom_range(0, 4)) - 2);
        if (p < 0) p = 0;
        if (p > 4095) p = 4095;
        pos = p[11:0];
        size = s[11:0];
    endfunction

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        reset_landmarks();
        list_matched = 1'b0;
    endtask

    task automatic test_empty_store();
        send_rect(0, 0, 4095, 4095);
        send_op(OP_END);
    endtask

    task automatic test_coordinate_extremes();
        send_op(OP_CLEAR);
        send_point(-32768, 32767);
        send_point(32767, -32768);
        send_rect(0, 0, 0, 0);
        send_rect(4095, 4095, 4095, 4095);
        send_rect(0, 0, 4095, 4095);
        send_op(OP_END);
    endtask

    task automatic test_match_rules();
        send_op(OP_CLEAR);
        send_point(16 * 100, 16 * 200);
        send_rect(99, 200, 0, 0);
        send_rect(100, 200, 0, 0);
        send_rect(0, 0, 4095, 4095);
        send_op(OP_END);
        send_op(OP_END);
        send_rect(100, 200, 0, 0);
        send_op(OP_CLEAR);
        send_op(OP_END);
    endtask

    task automatic test_span_limit();
        send_op(OP_CLEAR);
        send_point(0, 0);
        send_point(48, 48);
        send_rect(0, 0, 1, 1);
        send_rect(0, 0, 2, 2);
        send_op(OP_END);
    endtask

    task automatic run_landmark_list();
        int npts;
        int ncand;
        int sp;
        int cx;
        int cy;
        int kind;
        logic [11:0] fl;
        logic [11:0] ft;
        logic [11:0] fw;
        logic [11:0] fh;
        if ($urandom_range(0, 9) != 0) send_op(OP_CLEAR);
        if ($urandom_range(0, 29) == 0) npts = 0;
        else if ($urandom_range(0, 19) == 0) npts = $urandom_range(120, 140);
        else npts = $urandom_range(1, 16);
        sp = $urandom_range(0, 200);
        cx = $urandom_range(sp, 2046 - sp);
        cy = $urandom_range(sp, 2046 - sp);
        for (int i = 0; i < npts; i++) begin
            send_point((cx + int'($urandom_range(0, 2 * sp)) - sp) * 16
                           + $urandom_range(0, 15),
                       (cy + int'($urandom_range(0, 2 * sp)) - sp) * 16
                           + $urandom_range(0, 15));
        end
        ncand = $urandom_range(1, 8);
        for (int i = 0; i < ncand; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 5 || kind == 9) begin
                pick_fit(lm_sum_x, lm_least_x, lm_greatest_x, kind == 9, fl, fw);
                pick_fit(lm_sum_y, lm_least_y, lm_greatest_y, kind == 9, ft, fh);
                send_rect(int'(fl), int'(ft), int'(fw), int'(fh));
            end else if (kind < 8) begin
                send_rect($urandom(), $urandom(), $urandom(), $urandom());
            end else begin
                send_noise();
            end
        end
        if ($urandom_range(0, 9) != 0) send_op(OP_END);
        if ($urandom_range(0, 14) == 0) send_op(OP_END);
    endtask

    task automatic test_random_lists(int item_goal);
        int start;
        start = items_sent;
        while (items_sent - start < item_goal) begin
            if ($urandom_range(0, 7) == 0) send_noise();
            else run_landmark_list();
        end
    endtask

    task automatic test_output_stall();
        hold_length = 400;
        hold_serial++;
        tx_steady = 1'b1;
        send_op(OP_CLEAR);
        for (int i = 0; i < 60; i++) send_op(OP_END);
        tx_steady = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_steady_stream();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        test_random_lists(300);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial begin
        apply_reset();
        test_empty_store();
        test_coordinate_extremes();
        test_match_rules();
        test_span_limit();
        wait_results_drained();
        test_random_lists(800);
        wait_results_drained();
        test_output_stall();
        test_steady_stream();
        test_random_lists(800);
        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/fbl_pkg.sv
rtl/core/fbl_axis_fit.sv
rtl/core/face_box_landmark_check_core.sv
rtl/core/fbl_check.sv
tb/tb_face_box_landmark_check_core.sv
